>>> rtl/fdep_pkg.sv
package fdep_pkg;

	localparam int ENTRY_BYTES          = 32;
	localparam int CHARS_PER_LONG_ENTRY = 13;
	localparam int ENTRY_WORDS          = ENTRY_BYTES / 2;
	localparam int MEM_WORDS            = 2 * ENTRY_WORDS;

	localparam logic [4:0] POS_ATTR     = 5'd11;
	localparam logic [4:0] POS_LAST     = 5'(ENTRY_BYTES - 1);

	localparam logic [7:0] LONG_ATTR_MASK = 8'h0F;
	localparam logic [7:0] LAST_LONG_FLAG = 8'h40;
	localparam logic [7:0] MARK_DELETED   = 8'hE5;
	localparam logic [7:0] MARK_END       = 8'h00;

	localparam logic KIND_CHAR  = 1'b0;
	localparam logic KIND_SHORT = 1'b1;

	localparam logic [9:0] MAX_CHAR_INDEX = 10'd819;

	// drain steps: one per entry word, then one slot for the terminator
	localparam logic [4:0] DRAIN_LAST     = 5'(ENTRY_WORDS);
	localparam logic [4:0] ODD_GROUP_END  = 5'd5;
	localparam logic [4:0] WORD_EXT_LO    = 5'd4;
	localparam logic [4:0] WORD_EXT_HI    = 5'd5;
	localparam logic [4:0] WORD_CLUS_HI   = 5'd10;
	localparam logic [4:0] WORD_CLUS_LO   = 5'd13;
	localparam logic [4:0] WORD_SIZE_LO   = 5'd14;
	localparam logic [4:0] WORD_SIZE_HI   = 5'd15;

	typedef struct packed {
		logic       dir_restart;
		logic [7:0] data_byte;
	} fdep_in_t;

	typedef struct packed {
		logic        record_kind;
		logic [9:0]  char_index;
		logic [15:0] char_value;
		logic [63:0] short_name_head;
		logic [23:0] short_name_ext;
		logic [7:0]  attributes;
		logic [31:0] first_cluster;
		logic [31:0] file_size;
		logic        entry_live;
		logic        last_of_run;
	} fdep_out_t;

	function automatic logic char_step(input logic [4:0] step);
		logic hit;
		case (step) inside
			[5'd1:5'd5], [5'd7:5'd12], 5'd14, 5'd15: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	function automatic logic [3:0] char_num(input logic [4:0] step);
		logic [4:0] n;
		case (step) inside
			[5'd1:5'd5]:  n = step - 5'd1;
			[5'd7:5'd12]: n = step - 5'd2;
			default:      n = step - 5'd3;
		endcase
		return n[3:0];
	endfunction

endpackage

>>> rtl/fat32_dir_entry_parser_top.sv
// Directory entry parser: takes raw directory data one byte per item on the
// byte channel and returns long-name characters and short entry records on
// the rec channel. Both channels use valid/stall; an item moves on a clock
// edge with valid high and stall low.
// Every 32 bytes form one entry; dir_restart on a byte makes it byte 0 of a
// new entry and drops any partial one. A long-name entry yields 13 characters
// plus an optional terminator; a short entry yields one record; a long-name
// entry with ordinal zero yields nothing.
// Bytes are accepted one per cycle while byte_stall is low. Entries are
// stored as 16-bit words in a two-bank word memory; while one bank fills, the
// other is read back one word per cycle unless the output holds, and its
// results are built from the words. With the drain idle, a long-name entry's
// first character, or a short entry's record, passes the read stage and the
// output register before rec_valid rises. Characters follow one per cycle
// while rec_stall is low, with a gap after the fifth and the eleventh.
// Sustained rate is one byte per cycle while rec_stall is low, as an entry
// drains faster than it fills. While the receiver stalls, the current result
// holds and the drain pauses at its next result; byte_stall rises once both
// banks hold complete entries. Reset clears the byte position, bank pointers
// and valid flags; no result is pending after reset.
module fat32_dir_entry_parser_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  fdep_pkg::fdep_in_t  byte_item,
	output logic               rec_valid,
	input  logic               rec_stall,
	output fdep_pkg::fdep_out_t rec_item
);
	import fdep_pkg::*;

	typedef struct packed {
		logic       is_long;
		logic       last_flag;
		logic       live;
		logic [7:0] attr;
		logic [9:0] base;
	} meta_t;

	logic [4:0]  pos_q;
	logic [4:0]  pos;
	logic        wb_q;
	logic        rb_q;
	logic [1:0]  busy_q;
	logic [7:0]  lo_q;
	logic [7:0]  b0_q;
	logic [7:0]  attr_q;
	meta_t       meta_q [2];
	meta_t       meta_new;
	meta_t       meta_s1;
	logic        accept;
	logic        handoff;
	logic        skip;
	logic [5:0]  ord;

	logic [15:0] mem [MEM_WORDS];
	logic        mem_we;
	logic        mem_re;
	logic [4:0]  waddr;
	logic [4:0]  raddr;
	logic [15:0] wdata;
	logic [15:0] rdata_s1;

	logic [4:0]  step_q;
	logic [4:0]  step_s1;
	logic        v_s1;
	logic        issue;
	logic        adv_s1;
	logic        emit_s1;

	logic [7:0]  prev_hi_q;
	logic [63:0] head_q;
	logic [23:0] ext_q;
	logic [15:0] clus_hi_q;
	logic [15:0] clus_lo_q;
	logic [15:0] size_lo_q;

	fdep_out_t   res;
	fdep_out_t   out_q;
	logic        out_valid_q;

	assign byte_stall = busy_q[wb_q];
	assign accept     = byte_valid && !busy_q[wb_q];
	assign pos        = byte_item.dir_restart ? 5'd0 : pos_q;
	assign handoff    = accept && (pos == POS_LAST);
	assign ord        = b0_q[5:0];
	assign skip       = meta_new.is_long && (ord == 6'd0);

	assign mem_we = accept && pos[0];
	assign waddr  = {wb_q, pos[4:1]};
	assign wdata  = {byte_item.data_byte, lo_q};

	always_comb begin
		meta_new.is_long   = (attr_q & LONG_ATTR_MASK) == LONG_ATTR_MASK;
		meta_new.last_flag = (b0_q & LAST_LONG_FLAG) != 8'd0;
		meta_new.live      = (b0_q != MARK_DELETED) && (b0_q != MARK_END);
		meta_new.attr      = attr_q;
		meta_new.base      = 10'(({4'd0, ord} - 10'd1) * 10'(CHARS_PER_LONG_ENTRY));
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (!pos[0])
				lo_q <= byte_item.data_byte;
			if (pos == 5'd0)
				b0_q <= byte_item.data_byte;
			if (pos == POS_ATTR)
				attr_q <= byte_item.data_byte;
		end
		if (handoff && !skip)
			meta_q[wb_q] <= meta_new;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[waddr] <= wdata;
		if (mem_re)
			rdata_s1 <= mem[raddr];
	end

	assign emit_s1 = v_s1 && (meta_s1.is_long
		? (char_step(step_s1) || (step_s1 == DRAIN_LAST && meta_s1.last_flag))
		: (step_s1 == WORD_SIZE_HI));
	assign adv_s1  = !emit_s1 || !out_valid_q || !rec_stall;
	assign issue   = busy_q[rb_q] && (!v_s1 || adv_s1);
	assign mem_re  = issue && (step_q != DRAIN_LAST);
	assign raddr   = {rb_q, step_q[3:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= 5'd0;
			wb_q        <= 1'b0;
			rb_q        <= 1'b0;
			busy_q      <= 2'b00;
			step_q      <= 5'd0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				pos_q <= pos + 5'd1;
			if (handoff && !skip) begin
				busy_q[wb_q] <= 1'b1;
				wb_q         <= ~wb_q;
			end
			if (issue) begin
				if (step_q == DRAIN_LAST) begin
					busy_q[rb_q] <= 1'b0;
					rb_q         <= ~rb_q;
					step_q       <= 5'd0;
				end else begin
					step_q <= step_q + 5'd1;
				end
			end
			if (issue)
				v_s1 <= 1'b1;
			else if (adv_s1)
				v_s1 <= 1'b0;
			if (emit_s1 && adv_s1)
				out_valid_q <= 1'b1;
			else if (!rec_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			step_s1 <= step_q;
			meta_s1 <= meta_q[rb_q];
		end
		if (v_s1 && adv_s1) begin
			prev_hi_q <= rdata_s1[15:8];
			case (step_s1) inside
				[5'd0:5'd3]:  head_q[{step_s1[1:0], 4'd0} +: 16] <= rdata_s1;
				WORD_EXT_LO:  ext_q[15:0] <= rdata_s1;
				WORD_EXT_HI:  ext_q[23:16] <= rdata_s1[7:0];
				WORD_CLUS_HI: clus_hi_q <= rdata_s1;
				WORD_CLUS_LO: clus_lo_q <= rdata_s1;
				WORD_SIZE_LO: size_lo_q <= rdata_s1;
				default: ;
			endcase
		end
		if (emit_s1 && adv_s1)
			out_q <= res;
	end

	always_comb begin
		res = '0;
		if (meta_s1.is_long) begin
			res.record_kind = KIND_CHAR;
			if (step_s1 == DRAIN_LAST) begin
				res.char_index  = meta_s1.base + 10'(CHARS_PER_LONG_ENTRY);
				res.last_of_run = 1'b1;
			end else begin
				res.char_index  = meta_s1.base + {6'd0, char_num(step_s1)};
				res.char_value  = (step_s1 <= ODD_GROUP_END)
					? {rdata_s1[7:0], prev_hi_q} : rdata_s1;
				res.last_of_run = (step_s1 == WORD_SIZE_HI) && !meta_s1.last_flag;
			end
		end else begin
			res.record_kind     = KIND_SHORT;
			res.short_name_head = head_q;
			res.short_name_ext  = ext_q;
			res.attributes      = meta_s1.attr;
			res.first_cluster   = {clus_hi_q, clus_lo_q};
			res.file_size       = {rdata_s1, size_lo_q};
			res.entry_live      = meta_s1.live;
			res.last_of_run     = 1'b1;
		end
	end

	assign rec_valid = out_valid_q;
	assign rec_item  = out_q;

`ifndef SYNTH
	a_bank_split: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (waddr[4] != raddr[4]))
		else $error("write and read hit the same bank");

	a_bank_order: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q[rb_q] |-> (busy_q == 2'b00))
		else $error("full bank skipped by drain");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= DRAIN_LAST)
		else $error("drain step out of range");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.record_kind == KIND_CHAR)
		|-> (out_q.char_index <= MAX_CHAR_INDEX))
		else $error("char index out of range");
`endif

endmodule
